[rtl/assert_macros.svh]
// Assertion helpers for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg: shared constants and types
// Sizes, event codes, register indexes and structs of the capture stamp queue.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int NumChannels = 4;
  localparam int FifoDepth   = 64;

  localparam int KindW   = 2;
  localparam int ChanW   = 2;
  localparam int CapW    = 16;
  localparam int CoarseW = 48;
  localparam int StampW  = 64;
  localparam int OutLvlW = 7;
  localparam int ThrW    = 9;
  localparam int MaskW   = 4;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 9;

  localparam int PtrW   = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int LevelW = $clog2(FifoDepth + 1);
  localparam int TotalW = $clog2(NumChannels * FifoDepth + 1);
  localparam int AddrW  = $clog2(NumChannels * FifoDepth);
  localparam int Depth  = NumChannels * FifoDepth;

  localparam logic [StampW-1:0] LateStep = StampW'(64'h10000);
  localparam logic [ThrW-1:0]   ResetThreshold = ThrW'(15);

  typedef enum logic [KindW-1:0] {
    KIND_CAPTURE  = 2'd0,
    KIND_OVERFLOW = 2'd1,
    KIND_READ     = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAP_MASK  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OVF_EN    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [StampW-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } ram_rd_t;

endpackage

[rtl/cts_if.sv]
// ----------------------------------------------------------------------------
// cts_if: event and result channels
// Valid/ready channels that carry one event beat in and one result beat out.
// ----------------------------------------------------------------------------
interface cts_in_if;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::KindW-1:0]   kind;
  logic [cts_pkg::ChanW-1:0]   channel;
  logic [cts_pkg::CapW-1:0]    capture_value;
  logic [cts_pkg::CapW-1:0]    counter_now;
  logic                        late_capture;

  modport source (output valid, kind, channel, capture_value, counter_now, late_capture,
                  input ready);
  modport sink   (input valid, kind, channel, capture_value, counter_now, late_capture,
                  output ready);
endinterface

interface cts_out_if;
  logic                         valid;
  logic                         ready;
  logic [cts_pkg::StampW-1:0]   timestamp;
  logic                         timestamp_valid;
  logic                         dropped;
  logic [cts_pkg::OutLvlW-1:0]  channel_level;
  logic                         ready_res;

  modport source (output valid, timestamp, timestamp_valid, dropped, channel_level,
                  ready_res, input ready);
  modport sink   (input valid, timestamp, timestamp_valid, dropped, channel_level,
                  ready_res, output ready);
endinterface

[rtl/capture_timestamp_fifo.sv]
// ----------------------------------------------------------------------------
// capture_timestamp_fifo: per-channel capture timestamp queues
// Extends 16-bit captures to 64-bit stamps and queues them per channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one event beat: a capture, a timer overflow or a read of one
//   stamp from a channel. out_o returns exactly one result beat per event,
//   in event order: the popped stamp (reads only), a drop flag, the level of
//   the addressed channel after the event and the total-fill ready flag.
//   Captures and overflows are done at once: the result is registered at the
//   accepting edge and the next event can be accepted in the following cycle.
//   A read passes through ST_READ: the stamp store is a synchronous RAM, so
//   its port is addressed at the accepting edge and the data lands in the
//   result register in the cycle after; no event is taken in ST_READ.
//   The output register parts the two sides: a new event is taken while the
//   previous result is being taken in the same cycle. While the receiver
//   stalls a held result, hold the input side as well.
//   Configuration writes (cfg_we_i) take effect at the next edge and are
//   meant for idle periods only; index 3 is ignored.
//   Reset clears coarse count, pointers, fill counts and the result valid
//   flag and loads the register defaults; the stamp RAM is not cleared, since
//   only written entries are ever read back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module capture_timestamp_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cts_pkg::CfgW-1:0]    cfg_wdata_i,
  cts_in_if.sink                      in_i,
  cts_out_if.source                   out_o
);

  // Configuration registers
  logic [cts_pkg::ThrW-1:0]  thr_q;
  logic [cts_pkg::MaskW-1:0] mask_q;
  logic                      ovf_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= cts_pkg::ResetThreshold;
      mask_q   <= '1;
      ovf_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cts_pkg::CFG_THRESHOLD: thr_q    <= cfg_wdata_i[cts_pkg::ThrW-1:0];
        cts_pkg::CFG_CAP_MASK:  mask_q   <= cfg_wdata_i[cts_pkg::MaskW-1:0];
        cts_pkg::CFG_OVF_EN:    ovf_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Per-channel queue control and coarse count
  logic [cts_pkg::CoarseW-1:0] coarse_q, coarse_d;
  logic [cts_pkg::PtrW-1:0]    wptr_q [cts_pkg::NumChannels];
  logic [cts_pkg::PtrW-1:0]    wptr_d [cts_pkg::NumChannels];
  logic [cts_pkg::PtrW-1:0]    rptr_q [cts_pkg::NumChannels];
  logic [cts_pkg::PtrW-1:0]    rptr_d [cts_pkg::NumChannels];
  logic [cts_pkg::LevelW-1:0]  fill_q [cts_pkg::NumChannels];
  logic [cts_pkg::LevelW-1:0]  fill_d [cts_pkg::NumChannels];
  logic [cts_pkg::TotalW-1:0]  total_q, total_d;

  cts_pkg::state_e st_q, st_d;

  // Result register
  logic                         out_valid_q, out_valid_d;
  logic [cts_pkg::StampW-1:0]   ts_q, ts_d;
  logic                         tsv_q, tsv_d;
  logic                         drop_q, drop_d;
  logic [cts_pkg::OutLvlW-1:0]  lvl_q, lvl_d;
  logic                         rdy_q, rdy_d;

  cts_pkg::ram_wr_t            ram_wr;
  cts_pkg::ram_rd_t            ram_rd;
  logic [cts_pkg::StampW-1:0]  ram_rdata;

  logic                        in_ready;
  logic                        accept;
  logic [cts_pkg::ChanW-1:0]   ch;
  logic                        in_range;
  logic                        ch_full;
  logic                        late_hit;
  logic [cts_pkg::StampW-1:0]  stamp;
  cts_pkg::kind_e              kind;

  // Accept while idle and the result slot is free or draining this cycle.
  assign in_ready = (st_q == cts_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept   = in_i.valid && in_ready;

  assign kind     = cts_pkg::kind_e'(in_i.kind);
  assign ch       = in_i.channel;
  assign in_range = int'(ch) < cts_pkg::NumChannels;
  assign ch_full  = fill_q[ch] == cts_pkg::LevelW'(cts_pkg::FifoDepth);
  assign late_hit = in_i.late_capture && (in_i.capture_value < in_i.counter_now);
  assign stamp    = {coarse_q, in_i.capture_value}
                  + (late_hit ? cts_pkg::LateStep : '0);

  function automatic logic [cts_pkg::PtrW-1:0] ptr_inc(input logic [cts_pkg::PtrW-1:0] p);
    ptr_inc = (p == cts_pkg::PtrW'(cts_pkg::FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [cts_pkg::AddrW-1:0] ram_addr(
    input logic [cts_pkg::ChanW-1:0] c,
    input logic [cts_pkg::PtrW-1:0]  p
  );
    ram_addr = cts_pkg::AddrW'(c) * cts_pkg::AddrW'(cts_pkg::FifoDepth)
             + cts_pkg::AddrW'(p);
  endfunction

  always_comb begin
    coarse_d    = coarse_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    fill_d      = fill_q;
    total_d     = total_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    ts_d        = ts_q;
    tsv_d       = tsv_q;
    drop_d      = drop_q;
    lvl_d       = lvl_q;
    rdy_d       = rdy_q;
    ram_wr      = '{en: 1'b0, addr: ram_addr(ch, wptr_q[ch]), data: stamp};
    ram_rd      = '{en: 1'b0, addr: ram_addr(ch, rptr_q[ch])};

    // Drop the result once the receiver takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      cts_pkg::ST_IDLE: begin
        if (accept) begin
          drop_d = 1'b0;
          tsv_d  = 1'b0;
          ts_d   = '0;
          case (kind)
            cts_pkg::KIND_OVERFLOW: begin
              if (ovf_en_q) begin
                coarse_d = coarse_q + 1'b1;
              end
            end
            cts_pkg::KIND_CAPTURE: begin
              if (in_range && mask_q[ch]) begin
                if (ch_full) begin
                  drop_d = 1'b1;
                end else begin
                  ram_wr.en  = 1'b1;
                  wptr_d[ch] = ptr_inc(wptr_q[ch]);
                  fill_d[ch] = fill_q[ch] + 1'b1;
                  total_d    = total_q + 1'b1;
                end
              end
            end
            cts_pkg::KIND_READ: begin
              if (in_range && (fill_q[ch] != '0)) begin
                ram_rd.en  = 1'b1;
                tsv_d      = 1'b1;
                rptr_d[ch] = ptr_inc(rptr_q[ch]);
                fill_d[ch] = fill_q[ch] - 1'b1;
                total_d    = total_q - 1'b1;
              end
            end
            default: ;
          endcase
          lvl_d = in_range ? cts_pkg::OutLvlW'(fill_d[ch]) : '0;
          rdy_d = 32'(total_d) > 32'(thr_q);
          // A read waits for the RAM in ST_READ; everything else is done now.
          if (kind == cts_pkg::KIND_READ) begin
            out_valid_d = 1'b0;
            st_d        = cts_pkg::ST_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      cts_pkg::ST_READ: begin
        // Slot is free here: the accept only happened with it free or draining.
        ts_d        = tsv_q ? ram_rdata : '0;
        out_valid_d = 1'b1;
        st_d        = cts_pkg::ST_IDLE;
      end
      default: begin
        st_d = cts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_q    <= '0;
      total_q     <= '0;
      st_q        <= cts_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < cts_pkg::NumChannels; i++) begin
        wptr_q[i] <= '0;
        rptr_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      coarse_q    <= coarse_d;
      total_q     <= total_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q   <= ts_d;
    tsv_q  <= tsv_d;
    drop_q <= drop_d;
    lvl_q  <= lvl_d;
    rdy_q  <= rdy_d;
  end

  cts_stamp_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_i      (ram_rd),
    .rd_data_o (ram_rdata)
  );

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.timestamp       = ts_q;
  assign out_o.timestamp_valid = tsv_q;
  assign out_o.dropped         = drop_q;
  assign out_o.channel_level   = lvl_q;
  assign out_o.ready_res       = rdy_q;

  // Checks
  logic [cts_pkg::TotalW-1:0] fill_sum;
  always_comb begin
    fill_sum = '0;
    for (int i = 0; i < cts_pkg::NumChannels; i++) begin
      fill_sum = fill_sum + cts_pkg::TotalW'(fill_q[i]);
    end
  end

  `ASSERT_NEXT(a_read_two_cycles, clk_i, rst_ni,
               accept && (kind == cts_pkg::KIND_READ),
               (st_q == cts_pkg::ST_READ) && !out_valid_q ##1 out_valid_q)
  `ASSERT_IMPL(a_total_matches, clk_i, rst_ni, 1'b1, total_q == fill_sum)
  `ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, out_valid_q && !out_o.ready, !accept)

endmodule

[rtl/cts_stamp_ram.sv]
// ----------------------------------------------------------------------------
// cts_stamp_ram: stamp store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cts_stamp_ram (
  input  logic                       clk_i,
  input  cts_pkg::ram_wr_t           wr_i,
  input  cts_pkg::ram_rd_t           rd_i,
  output logic [cts_pkg::StampW-1:0] rd_data_o
);

  logic [cts_pkg::StampW-1:0] mem [cts_pkg::Depth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_o <= mem[rd_i.addr];
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: capture stamp queue check
// Drives capture, overflow, read and idle event beats into the block under
// random idling on both channels and predicts every result beat. The run
// steps through several register settings, between phases only.
// ----------------------------------------------------------------------------
module testbench;
  import cts_pkg::*;

  // Register index the block ignores; written once to confirm it has no effect
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int RandomTarget = 1100;

  typedef struct packed {
    kind_e              kind;
    logic [ChanW-1:0]   channel;
    logic [CapW-1:0]    capture_value;
    logic [CapW-1:0]    counter_now;
    logic               late_capture;
  } capture_evt_t;

  typedef struct packed {
    logic [StampW-1:0]  timestamp;
    logic               timestamp_valid;
    logic               dropped;
    logic [OutLvlW-1:0] channel_level;
    logic               ready_res;
  } stamp_result_t;

  // Shadow of the block: coarse count, per-channel stamp rings and settings.
  // Results come back in event order, so one queue holds them all.
  class stamp_scoreboard;
    logic [CoarseW-1:0] coarse;
    logic [StampW-1:0]  stamps [NumChannels][FifoDepth];
    int                 wr_ptr [NumChannels];
    int                 rd_ptr [NumChannels];
    int                 fill   [NumChannels];
    logic [ThrW-1:0]    threshold;
    logic [MaskW-1:0]   cap_mask;
    logic               ovf_en;
    stamp_result_t      due_results [$];
    int mismatches, n_results, n_stored, n_dropped, n_popped, n_empty_reads, n_overflows;

    function new();
      coarse    = '0;
      threshold = ResetThreshold;
      cap_mask  = '1;
      ovf_en    = 1'b1;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_THRESHOLD: threshold = value[ThrW-1:0];
        CFG_CAP_MASK:  cap_mask  = value[MaskW-1:0];
        CFG_OVF_EN:    ovf_en    = value[0];
        default: ;
      endcase
    endfunction

    function int total_fill();
      int sum;
      sum = 0;
      foreach (fill[c]) sum += fill[c];
      return sum;
    endfunction

    function void note_event(capture_evt_t e);
      stamp_result_t r;
      logic [StampW-1:0] v;
      int ch;
      r  = '0;
      ch = e.channel;
      case (e.kind)
        KIND_OVERFLOW: begin
          n_overflows++;
          if (ovf_en) coarse = coarse + 1'b1;
        end
        KIND_CAPTURE: begin
          if (cap_mask[ch]) begin
            if (fill[ch] >= FifoDepth) begin
              r.dropped = 1'b1;
              n_dropped++;
            end else begin
              v = {coarse, {CapW{1'b0}}} + StampW'(e.capture_value);
              // late capture below the live counter belongs after the overflow
              if (e.late_capture && e.capture_value < e.counter_now) v = v + LateStep;
              stamps[ch][wr_ptr[ch]] = v;
              wr_ptr[ch] = (wr_ptr[ch] + 1) % FifoDepth;
              fill[ch]++;
              n_stored++;
            end
          end
        end
        KIND_READ: begin
          if (fill[ch] > 0) begin
            r.timestamp       = stamps[ch][rd_ptr[ch]];
            r.timestamp_valid = 1'b1;
            rd_ptr[ch] = (rd_ptr[ch] + 1) % FifoDepth;
            fill[ch]--;
            n_popped++;
          end else begin
            n_empty_reads++;
          end
        end
        default: ;
      endcase
      r.channel_level = OutLvlW'(fill[ch]);
      r.ready_res     = total_fill() > threshold;
      due_results.push_back(r);
    endfunction

    function void flag(string field, logic [StampW-1:0] want, logic [StampW-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %0d field %s: expected 0x%0h, got 0x%0h",
                 $time, n_results, field, want, got);
    endfunction

    function void check_result(stamp_result_t got);
      stamp_result_t want;
      if (due_results.size() == 0) begin
        flag("beat (none outstanding)", '0, got.timestamp);
        return;
      end
      want = due_results.pop_front();
      if (got.timestamp !== want.timestamp) flag("timestamp", want.timestamp, got.timestamp);
      if (got.timestamp_valid !== want.timestamp_valid)
        flag("timestamp_valid", want.timestamp_valid, got.timestamp_valid);
      if (got.dropped !== want.dropped) flag("dropped", want.dropped, got.dropped);
      if (got.channel_level !== want.channel_level)
        flag("channel_level", want.channel_level, got.channel_level);
      if (got.ready_res !== want.ready_res) flag("ready_res", want.ready_res, got.ready_res);
      n_results++;
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  // Phases with these set run without idling on that side
  logic               send_burst;
  logic               recv_burst;

  stamp_scoreboard sb = new();

  cts_in_if  ev_if ();
  cts_out_if res_if ();

  capture_timestamp_fifo u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (ev_if),
    .out_o       (res_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", sb.due_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sample both channels at the edge: note each accepted event beat, then
  // check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    if (ev_if.valid && ev_if.ready)
      sb.note_event('{kind_e'(ev_if.kind), ev_if.channel, ev_if.capture_value,
                      ev_if.counter_now, ev_if.late_capture});
    if (res_if.valid && res_if.ready)
      sb.check_result('{res_if.timestamp, res_if.timestamp_valid, res_if.dropped,
                        res_if.channel_level, res_if.ready_res});
  end

  // Result side: stall a random number of cycles before taking each beat
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Hold one event beat after a random gap until the block takes it
  task automatic send_event(capture_evt_t e);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_if.valid         <= 1'b1;
    ev_if.kind          <= e.kind;
    ev_if.channel       <= e.channel;
    ev_if.capture_value <= e.capture_value;
    ev_if.counter_now   <= e.counter_now;
    ev_if.late_capture  <= e.late_capture;
    do @(posedge clk); while (!ev_if.ready);
  endtask

  // Drop valid and wait until every predicted result has come back, then
  // keep waiting so the block is surely idle.
  task automatic settle();
    ev_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic capture_evt_t mk(kind_e k, int ch, int cap, int now, bit late);
    return '{k, ChanW'(ch), CapW'(cap), CapW'(now), late};
  endfunction

  // mode 0 mixes all events, mode 1 fills one channel, mode 2 drains
  function automatic capture_evt_t random_event(int mode, int focus);
    capture_evt_t e;
    int roll, cap_pct, rd_pct;
    case (mode)
      1: begin cap_pct = 80; rd_pct = 15; end
      2: begin cap_pct = 15; rd_pct = 75; end
      default: begin cap_pct = 45; rd_pct = 35; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < cap_pct) e.kind = KIND_CAPTURE;
    else if (roll < cap_pct + rd_pct) e.kind = KIND_READ;
    else if (roll < 97) e.kind = KIND_OVERFLOW;
    else e.kind = KIND_NONE;
    e.channel = (mode == 1 && $urandom_range(0, 3) != 0) ? ChanW'(focus)
                                                          : ChanW'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: e.capture_value = '0;
      1: e.capture_value = '1;
      default: e.capture_value = CapW'($urandom);
    endcase
    // keep the live counter near the capture often so both sides of the
    // late comparison come up
    if ($urandom_range(0, 1))
      e.counter_now = e.capture_value + CapW'($urandom_range(0, 4)) - CapW'(2);
    else
      e.counter_now = CapW'($urandom);
    e.late_capture = 1'($urandom_range(0, 1));
    return e;
  endfunction

  initial begin
    capture_evt_t directed [$];
    capture_evt_t item;
    logic [ThrW-1:0]  thr;
    logic [MaskW-1:0] mask;
    logic             ovf;
    int sent, phase, span, mode, focus;

    sent   = 0;
    phase  = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_THRESHOLD;
    cfg_wdata <= '0;
    ev_if.valid         <= 1'b0;
    ev_if.kind          <= KIND_NONE;
    ev_if.channel       <= '0;
    ev_if.capture_value <= '0;
    ev_if.counter_now   <= '0;
    ev_if.late_capture  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening under reset settings: field extremes, late captures on
    // both sides of the counter, late flag on an overflow, empty reads and
    // the idle event code.
    directed.push_back(mk(KIND_CAPTURE,  0, 16'h0000, 16'h0000, 1'b0));
    directed.push_back(mk(KIND_CAPTURE,  1, 16'hFFFF, 16'hFFFF, 1'b1));
    directed.push_back(mk(KIND_CAPTURE,  2, 16'h0000, 16'hFFFF, 1'b1));
    directed.push_back(mk(KIND_CAPTURE,  3, 16'h7FFF, 16'h8000, 1'b1));
    directed.push_back(mk(KIND_CAPTURE,  3, 16'h8000, 16'h7FFF, 1'b1));
    directed.push_back(mk(KIND_OVERFLOW, 3, 16'hFFFF, 16'hFFFF, 1'b1));
    directed.push_back(mk(KIND_CAPTURE,  0, 16'hABCD, 16'hABCE, 1'b0));
    directed.push_back(mk(KIND_OVERFLOW, 1, 16'h0000, 16'h0000, 1'b0));
    directed.push_back(mk(KIND_CAPTURE,  1, 16'h5555, 16'hAAAA, 1'b1));
    repeat (3) directed.push_back(mk(KIND_READ, 0, 16'h0000, 16'h0000, 1'b0));
    repeat (2) directed.push_back(mk(KIND_READ, 1, 16'hFFFF, 16'h0000, 1'b1));
    repeat (2) directed.push_back(mk(KIND_READ, 2, 16'h1234, 16'h4321, 1'b0));
    repeat (3) directed.push_back(mk(KIND_READ, 3, 16'h0000, 16'hFFFF, 1'b1));
    directed.push_back(mk(KIND_NONE, 2, 16'hFFFF, 16'hFFFF, 1'b1));
    foreach (directed[i]) send_event(directed[i]);
    settle();

    // Random phases, each under its own settings, until the event target is
    // reached.
    while (sent < RandomTarget) begin
      case (phase)
        0: begin thr = 9'd0;   mask = 4'hF;    ovf = 1'b1; end
        1: begin thr = 9'd256; mask = 4'h0;    ovf = 1'b0; end
        2: begin thr = 9'd511; mask = 4'b1010; ovf = 1'b1; end
        3: begin thr = 9'd15;  mask = 4'b0101; ovf = 1'b1; end
        default: begin
          case ($urandom_range(0, 5))
            0: thr = 9'd0;
            1: thr = 9'd256;
            default: thr = ThrW'($urandom_range(0, 64));
          endcase
          mask = $urandom_range(0, 1) ? 4'hF : MaskW'($urandom);
          ovf  = $urandom_range(0, 3) != 0;
        end
      endcase
      // upper data bits beyond the mask and enable register widths must be dropped
      write_reg(CFG_THRESHOLD, thr);
      write_reg(CFG_CAP_MASK, {5'($urandom), mask});
      write_reg(CFG_OVF_EN, {8'($urandom), ovf});
      if (phase == 2) write_reg(CFG_SPARE, 9'($urandom));

      mode       = phase % 3;
      focus      = $urandom_range(0, 3);
      span       = (mode == 1) ? $urandom_range(100, 160) : $urandom_range(40, 120);
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      repeat (span) begin
        item = random_event(mode, focus);
        send_event(item);
        sent++;
      end
      settle();
      phase++;
    end

    // Catch any stray result beat after the last one predicted
    repeat (10) @(posedge clk);
    $display("Ran %0d setting phases; %0d results checked, %0d mismatches.",
             phase, sb.n_results, sb.mismatches);
    $display("Stored %0d stamps, dropped %0d on full queues, popped %0d,",
             sb.n_stored, sb.n_dropped, sb.n_popped);
    $display("  %0d empty reads, %0d overflows.", sb.n_empty_reads, sb.n_overflows);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/cts_pkg.sv
rtl/cts_if.sv
rtl/cts_stamp_ram.sv
rtl/capture_timestamp_fifo.sv
verif/testbench.sv
